// ===== src/rzls_pkg.sv =====
`default_nettype none

package rzls_pkg;

    // pulse width, tick and pattern widths
    localparam int WIDTH_W    = 16;
    localparam int TICK_W     = 32;
    localparam int STEP_COUNT = 18;
    localparam int STEP_W     = $clog2(STEP_COUNT);
    localparam int DUR_W      = 11;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 8;

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOS_THRESHOLD = 2'd0,
        CFG_ON_MIN        = 2'd1,
        CFG_ON_MAX        = 2'd2
    } cfg_idx_t;

    localparam logic [WIDTH_W-1:0] SOS_THRESHOLD_RST = 16'd1750;
    localparam logic [WIDTH_W-1:0] ON_MIN_RST        = 16'd1000;
    localparam logic [WIDTH_W-1:0] ON_MAX_RST        = 16'd1250;

    typedef struct packed {
        logic [WIDTH_W-1:0] sos_threshold_us;
        logic [WIDTH_W-1:0] on_min_us;
        logic [WIDTH_W-1:0] on_max_us;
    } cfg_t;

    typedef enum logic [1:0] {
        ZONE_OFF = 2'd0,
        ZONE_ON  = 2'd1,
        ZONE_SOS = 2'd2
    } zone_t;

    // morse sos step durations in ms: dots 150, dashes 450, gap 1050
    function automatic logic [DUR_W-1:0] step_duration(input logic [STEP_W-1:0] step);
        logic [DUR_W-1:0] dur;
        case (step)
            5'd5, 5'd6, 5'd8, 5'd10, 5'd11: dur = 11'd450;
            5'd17:                          dur = 11'd1050;
            default:                        dur = 11'd150;
        endcase
        return dur;
    endfunction

endpackage

`default_nettype wire

// ===== src/rzls_cfg_regs.sv =====
`default_nettype none

module rzls_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rzls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rzls_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rzls_pkg::cfg_t                        cfg
);

    rzls_pkg::cfg_t cfg_reg;
    rzls_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // decode the register index, unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                rzls_pkg::CFG_SOS_THRESHOLD: cfg_next.sos_threshold_us = cfg_data;
                rzls_pkg::CFG_ON_MIN:        cfg_next.on_min_us        = cfg_data;
                rzls_pkg::CFG_ON_MAX:        cfg_next.on_max_us        = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sos_threshold_us <= rzls_pkg::SOS_THRESHOLD_RST;
            cfg_reg.on_min_us        <= rzls_pkg::ON_MIN_RST;
            cfg_reg.on_max_us        <= rzls_pkg::ON_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/rzls_zone.sv =====
`default_nettype none

module rzls_zone (
    input  wire logic [rzls_pkg::WIDTH_W-1:0] width,
    input  wire rzls_pkg::cfg_t               cfg,
    output rzls_pkg::zone_t                   zone
);

    // sos test wins over the on window
    always_comb begin
        if (width > cfg.sos_threshold_us) begin
            zone = rzls_pkg::ZONE_SOS;
        end else if (width >= cfg.on_min_us && width < cfg.on_max_us) begin
            zone = rzls_pkg::ZONE_ON;
        end else begin
            zone = rzls_pkg::ZONE_OFF;
        end
    end

endmodule

`default_nettype wire

// ===== src/rzls_seq_core.sv =====
`default_nettype none

module rzls_seq_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          fire,
    input  wire rzls_pkg::zone_t               zone,
    input  wire logic [rzls_pkg::TICK_W-1:0]   now_ms,
    output logic                               lamp_next
);

    logic [rzls_pkg::STEP_W-1:0] step_reg;
    logic [rzls_pkg::STEP_W-1:0] step_next;
    logic [rzls_pkg::TICK_W-1:0] last_change_reg;
    logic [rzls_pkg::TICK_W-1:0] last_change_next;
    logic                        lamp_reg;

    logic [rzls_pkg::STEP_W-1:0] step_cur;
    logic [rzls_pkg::TICK_W-1:0] elapsed;
    logic                        due;

    // out of range step restarts the pattern
    assign step_cur = (step_reg >= rzls_pkg::STEP_W'(rzls_pkg::STEP_COUNT)) ?
                      '0 : step_reg;
    assign elapsed  = now_ms - last_change_reg;
    assign due      = elapsed >= {{(rzls_pkg::TICK_W-rzls_pkg::DUR_W){1'b0}},
                                  rzls_pkg::step_duration(step_cur)};

    // next pattern state and lamp level
    always_comb begin
        step_next        = '0;
        last_change_next = last_change_reg;
        lamp_next        = 1'b0;
        case (zone)
            rzls_pkg::ZONE_SOS: begin
                lamp_next = lamp_reg;
                step_next = step_cur;
                if (due) begin
                    last_change_next = now_ms;
                    lamp_next        = ~step_cur[0];
                    step_next        = (step_cur == rzls_pkg::STEP_W'(rzls_pkg::STEP_COUNT-1)) ?
                                       '0 : step_cur + 1'b1;
                end
            end
            rzls_pkg::ZONE_ON: begin
                lamp_next = 1'b1;
            end
            default: begin
                lamp_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg        <= '0;
            last_change_reg <= '0;
            lamp_reg        <= 1'b0;
        end else if (fire) begin
            step_reg        <= step_next;
            last_change_reg <= last_change_next;
            lamp_reg        <= lamp_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/rc_zone_light_sos_sequencer.sv =====
`default_nettype none

// channel  | ports      | beat contents
// ---------+------------+------------------------------------------------
// input    | s_t*       | pulse_width_us, now_ms
// result   | m_t*       | lamp_on, one beat per input beat
// config   | cfg_*      | register index and 16-bit value
//
// every input beat passes the input register, then the result register
// one beat per cycle sustained while m_tready is high; the pattern state updates as a beat moves to the result register
// aresetn is synchronous, active low; it clears config to defaults and the pattern to step 0
// a stalled result holds; the input register still takes a beat when the result moves out

module rc_zone_light_sos_sequencer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [15:0] pulse_width_us, [47:16] now_ms
    input  wire logic [rzls_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] lamp_on, [7:1] zero
    output logic [rzls_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rzls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rzls_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rzls_pkg::cfg_t  cfg;
    rzls_pkg::zone_t zone;

    logic                           in_vld_reg;
    logic                           in_vld_next;
    logic [rzls_pkg::WIDTH_W-1:0]   in_width_reg;
    logic [rzls_pkg::TICK_W-1:0]    in_now_reg;
    logic                           out_vld_reg;
    logic                           out_vld_next;
    logic                           out_lamp_reg;
    logic                           lamp_next;
    logic                           fire;
    logic                           s_fire;

    rzls_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rzls_zone u_zone (
        .width (in_width_reg),
        .cfg   (cfg),
        .zone  (zone)
    );

    rzls_seq_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .zone      (zone),
        .now_ms    (in_now_reg),
        .lamp_next (lamp_next)
    );

    // handshake between the two register stages
    assign fire         = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready     = !in_vld_reg || fire;
    assign s_fire       = s_tvalid && s_tready;
    assign in_vld_next  = s_fire || (in_vld_reg && !fire);
    assign out_vld_next = fire || (out_vld_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // input beat capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_width_reg <= s_tdata[rzls_pkg::WIDTH_W-1:0];
            in_now_reg   <= s_tdata[rzls_pkg::WIDTH_W +: rzls_pkg::TICK_W];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_lamp_reg <= lamp_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(rzls_pkg::M_TDATA_W-1){1'b0}}, out_lamp_reg};

endmodule

`default_nettype wire

// ===== src/rzls_checker.sv =====
`default_nettype none

module rzls_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [rzls_pkg::M_TDATA_W-1:0]    m_tdata
);

    // a stalled result beat stays valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its data
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // an input beat accepted while no result is pending shows up as a result once it has passed both registers
    a_in_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("accepted beat gave no result");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[rzls_pkg::M_TDATA_W-1:1] == '0)
        else $error("result padding not zero");

endmodule

bind rc_zone_light_sos_sequencer rzls_checker u_rzls_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire
